// ===== rtl/idp_pkg.sv =====
// Shared types and constants of the interval depth packer.
package idp_pkg;

	localparam int START_W     = 62;
	localparam int DUR_W       = 63;
	localparam int DEPTH_W     = 6;
	localparam int STATUS_W    = 2;
	localparam int IN_DATA_W   = 128;
	localparam int OUT_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK,
		STATUS_ORDER,
		STATUS_FULL
	} idp_status_t;

	typedef enum logic [1:0] {
		KIND_ORDER_ERR,
		KIND_INSTANT,
		KIND_OPEN,
		KIND_TIMED
	} idp_kind_t;

	typedef struct packed {
		idp_kind_t            kind;
		logic [START_W-1:0]   start_time;
		logic [DUR_W-1:0]     end_time;
	} idp_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} idp_qstat_t;

endpackage

// ===== rtl/interval_depth_packer.sv =====
// Top level of the interval depth packer: front end, queue and back end.
//
// Packs intervals into depth slots first-fit. Send intervals in non-decreasing
// start order; each transfer on the slave side yields exactly one transfer on
// the master side, in order. A duration of zero is an instant (it reports the
// lowest free slot but occupies nothing), any negative duration never ends,
// and a positive one occupies its slot until a later start reaches
// start + duration. A start below the previous in-order start returns status 1
// with the previous depth and changes nothing; when every slot is occupied the
// result is status 2 with the previous depth. Throughput is one interval per
// clock while the master side accepts; each interval is written into the queue
// and its result is registered at the back end's output as it leaves. The rate
// is set by the back end, which compares all MAX_DEPTHS per-slot end registers
// against the start and priority-encodes the free slots combinationally. A
// four-entry queue between front and back end lets either side stall alone.
// Depths at or above 64 (only with MAX_DEPTHS above 64) wrap modulo 64.
module interval_depth_packer import idp_pkg::*; #(
	parameter int MAX_DEPTHS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata: start_time [61:0], duration [124:62], zero [127:125]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// m_tdata: depth [5:0], status [7:6]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	idp_qstat_t q_stat;
	idp_entry_t push_entry;
	idp_entry_t head;
	logic       push;
	logic       pop;

	// Classify each transfer and compute its end time.
	idp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Hold classified intervals until the back end is free.
	idp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_stat     (q_stat),
		.head       (head)
	);

	// Free expired slots, take the lowest free one, register the result.
	idp_back #(
		.MAX_DEPTHS (MAX_DEPTHS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	// Never read an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.valid)
		else $error("queue popped while empty");

	// Never write a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue pushed while full");

	// A popped entry shows up as a result on the next cycle.
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid)
		else $error("popped entry produced no result");

	// An accepted slot lies inside the slot range.
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7:6] == STATUS_OK) |->
			(MAX_DEPTHS >= 64 || m_tdata[5:0] < MAX_DEPTHS))
		else $error("depth outside slot range");
`endif

endmodule

// ===== rtl/idp_front.sv =====
// Front end: accepts intervals, checks start order and computes end times.
module idp_front import idp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  idp_qstat_t           q_stat,
	output logic                 push,
	output idp_entry_t           push_entry
);

	logic [START_W-1:0] last_start_q;
	logic [START_W-1:0] start_time;
	logic [DUR_W-1:0]   duration;
	logic               out_of_order;

	assign start_time   = s_tdata[START_W-1:0];
	assign duration     = s_tdata[START_W+DUR_W-1:START_W];
	assign out_of_order = start_time < last_start_q;

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_entry.start_time = start_time;
		push_entry.end_time   = {1'b0, start_time} + duration;
		if (out_of_order) begin
			push_entry.kind = KIND_ORDER_ERR;
		end else if (duration == '0) begin
			push_entry.kind = KIND_INSTANT;
		end else if (duration[DUR_W-1]) begin
			push_entry.kind = KIND_OPEN;
		end else begin
			push_entry.kind = KIND_TIMED;
		end
	end

	// Advance the order reference only on an in-order transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_start_q <= '0;
		end else if (push && !out_of_order) begin
			last_start_q <= start_time;
		end
	end

endmodule

// ===== rtl/idp_queue.sv =====
// Short FIFO of classified intervals between front and back end.
module idp_queue import idp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  idp_entry_t push_entry,
	input  logic       pop,
	output idp_qstat_t q_stat,
	output idp_entry_t head
);

	idp_entry_t         store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.valid = count_q != '0;
	assign head         = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/idp_back.sv =====
// Back end: frees expired slots, picks the lowest free slot, drives results.
module idp_back import idp_pkg::*; #(
	parameter int MAX_DEPTHS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  idp_qstat_t            q_stat,
	input  idp_entry_t            head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(MAX_DEPTHS);

	logic [MAX_DEPTHS-1:0] busy_q;
	logic [MAX_DEPTHS-1:0] has_end_q;
	logic [DUR_W-1:0]      end_q [MAX_DEPTHS];
	logic [DEPTH_W-1:0]    last_depth_q;
	logic                  m_valid_q;
	logic [DEPTH_W-1:0]    m_depth_q;
	idp_status_t           m_status_q;

	logic [MAX_DEPTHS-1:0] expired;
	logic [MAX_DEPTHS-1:0] busy_left;
	logic [MAX_DEPTHS-1:0] busy_next;
	logic [MAX_DEPTHS-1:0] has_end_next;
	logic                  found;
	logic [IDX_W-1:0]      pick;
	logic [DEPTH_W-1:0]    pick_depth;
	logic                  take;

	assign pop      = q_stat.valid && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_status_q, m_depth_q};

	// One comparator per slot against the incoming start.
	always_comb begin
		for (int i = 0; i < MAX_DEPTHS; i++) begin
			expired[i] = has_end_q[i] && (end_q[i] <= {1'b0, head.start_time});
		end
	end

	assign busy_left = busy_q & ~expired;
	assign found     = busy_left != '1;

	always_comb begin
		pick = '0;
		for (int i = MAX_DEPTHS - 1; i >= 0; i--) begin
			if (!busy_left[i]) begin
				pick = IDX_W'(i);
			end
		end
	end

	assign pick_depth = DEPTH_W'(pick);
	assign take = pop && (head.kind != KIND_ORDER_ERR) && found;

	// Drop expired slots, then occupy the picked one unless the interval is instant.
	always_comb begin
		busy_next    = busy_left;
		has_end_next = has_end_q & ~expired;
		if (found) begin
			unique case (head.kind)
				KIND_TIMED: begin
					busy_next[pick]    = 1'b1;
					has_end_next[pick] = 1'b1;
				end
				KIND_OPEN: begin
					busy_next[pick]    = 1'b1;
					has_end_next[pick] = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			has_end_q    <= '0;
			last_depth_q <= '0;
		end else if (pop && head.kind != KIND_ORDER_ERR) begin
			busy_q    <= busy_next;
			has_end_q <= has_end_next;
			if (found) begin
				last_depth_q <= pick_depth;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head.kind == KIND_TIMED) begin
			end_q[pick] <= head.end_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.kind == KIND_ORDER_ERR) begin
				m_depth_q  <= last_depth_q;
				m_status_q <= STATUS_ORDER;
			end else if (!found) begin
				m_depth_q  <= last_depth_q;
				m_status_q <= STATUS_FULL;
			end else begin
				m_depth_q  <= pick_depth;
				m_status_q <= STATUS_OK;
			end
		end
	end

endmodule

// ===== dv/interval_depth_packer_checker.sv =====
// Scoreboard for the interval depth packer: predicts depth and status per transfer and compares.
module interval_depth_packer_checker import idp_pkg::*; #(
	parameter int MAX_DEPTHS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		idp_status_t        status;
	} placement_t;

	// Shadow copy of the slot file
	logic                 occupied [MAX_DEPTHS];
	logic                 timed    [MAX_DEPTHS];
	logic [DUR_W-1:0]     ends_at  [MAX_DEPTHS];
	logic [START_W-1:0]   prev_start;
	logic [DEPTH_W-1:0]   prev_depth;

	placement_t placements_due[$];
	placement_t want;

	// First fit: free expired slots, take the lowest free one.
	function automatic placement_t place_interval(input logic [START_W-1:0] st,
			input logic [DUR_W-1:0] du);
		placement_t r;
		logic       found;
		int         pick;
		found = 1'b0;
		pick  = 0;
		if (st < prev_start) begin
			r.depth  = prev_depth;
			r.status = STATUS_ORDER;
			return r;
		end
		prev_start = st;
		for (int i = 0; i < MAX_DEPTHS; i++) begin
			if (timed[i] && ends_at[i] <= {1'b0, st}) begin
				occupied[i] = 1'b0;
				timed[i]    = 1'b0;
			end
		end
		for (int i = 0; i < MAX_DEPTHS; i++) begin
			if (!found && !occupied[i]) begin
				pick  = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			r.depth  = prev_depth;
			r.status = STATUS_FULL;
			return r;
		end
		// an instant reports the slot but leaves it free
		if (du != '0) begin
			occupied[pick] = 1'b1;
			if (!du[DUR_W-1]) begin
				timed[pick]   = 1'b1;
				ends_at[pick] = {1'b0, st} + du;
			end else begin
				timed[pick] = 1'b0;
			end
		end
		prev_depth = pick[DEPTH_W-1:0];
		r.depth    = prev_depth;
		r.status   = STATUS_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DEPTHS; i++) begin
				occupied[i] = 1'b0;
				timed[i]    = 1'b0;
				ends_at[i]  = '0;
			end
			prev_start = '0;
			prev_depth = '0;
			placements_due.delete();
			fail_count  = 0;
			results_due = 0;
		end else begin
			if (s_tvalid && s_tready)
				placements_due.insert(placements_due.size(),
					place_interval(s_tdata[START_W-1:0],
						s_tdata[START_W+DUR_W-1:START_W]));
			if (m_tvalid && m_tready) begin
				if (placements_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result transfer, depth %0d status %0d",
							$realtime, m_tdata[DEPTH_W-1:0], m_tdata[7:6]);
					fail_count++;
				end else begin
					want = placements_due.pop_front();
					if (m_tdata[DEPTH_W-1:0] != want.depth || m_tdata[7:6] != want.status) begin
						if (fail_count < 10)
							$display("%0t: mismatch, expected depth %0d status %0d, %s %0d %s %0d",
								$realtime, want.depth, want.status, "got depth",
								m_tdata[DEPTH_W-1:0], "status", m_tdata[7:6]);
						fail_count++;
					end
				end
			end
			results_due = placements_due.size();
		end
	end

endmodule

// ===== dv/interval_depth_packer_tb.sv =====
// Testbench top for the interval depth packer: clock, reset, interval stimulus and verdict.
module interval_depth_packer_tb;
	import idp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam logic [START_W-1:0] START_MAX = '1;
	localparam logic [DUR_W-1:0]   DUR_MAX   = {1'b0, {(DUR_W-1){1'b1}}};
	localparam logic [DUR_W-1:0]   NEVER     = '1;
	localparam logic [DUR_W-1:0]   NEG_MOST  = {1'b1, {(DUR_W-1){1'b0}}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fail_count;
	int                    results_due;

	// Last in-order start the block has accepted, mirrored for stimulus shaping
	logic [START_W-1:0] cur_start = '0;
	int                 sent = 0;
	int                 never_left = 8;
	int                 huge_left = 8;
	bit                 steady = 1'b0;
	bit                 late_phase = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	interval_depth_packer #(.MAX_DEPTHS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	interval_depth_packer_checker #(.MAX_DEPTHS(SLOTS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	// Result side: stall about one cycle in five, never during the steady window.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 20);
	end

	function automatic logic [START_W-1:0] rand_start();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[START_W-1:0];
	endfunction

	// Streaming durations: mostly short, some instants, a rationed few that
	// hold a slot forever or for a very long time.
	function automatic logic [DUR_W-1:0] stream_dur();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			return '0;
		if (roll < 14 && never_left > 0) begin
			never_left--;
			return {1'b1, rand_start()};
		end
		if (roll < 16 && huge_left > 0) begin
			huge_left--;
			return {1'b0, rand_start()};
		end
		return DUR_W'($urandom_range(1, 40));
	endfunction

	// Offer one interval, idling first at random; advance on the transfer.
	task automatic issue(input logic [START_W-1:0] st, input logic [DUR_W-1:0] du);
		while (!steady && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, du, st};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (st >= cur_start)
			cur_start = st;
		sent++;
		steady = (sent >= 700 && sent < 1000);
	endtask

	initial begin
		int unsigned pick;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: instant on empty file, short, never-ending (both encodings),
		// out-of-order, expiry exactly at the end time, the longest duration.
		issue('0, '0);
		issue('0, DUR_W'(5));
		issue('0, NEVER);
		issue('0, NEG_MOST);
		issue(START_W'(3), '0);
		issue(START_W'(2), DUR_W'(1));
		issue(START_W'(5), DUR_W'(10));
		issue(START_W'(5), DUR_MAX);
		issue(START_W'(14), DUR_W'(1));
		issue(START_W'(15), '0);
		issue(START_W'(15), DUR_W'(1));
		issue(START_W'(16), DUR_W'(2));

		while (sent < 1800) begin
			// Late on, jump the start high so the upper start bits get exercised.
			if (!late_phase && sent >= 1550) begin
				late_phase = 1'b1;
				issue(START_W'(62'h3FF0_0000_0000_0000) | START_W'($urandom()), stream_dur());
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				repeat ($urandom_range(20, 60))
					issue(cur_start + START_W'($urandom_range(0, 6)), stream_dur());
			end else if (pick < 75) begin
				// Burst of long intervals at nearly one start: can fill the file to overflow,
				// then step past every end so the slots drain.
				repeat ($urandom_range(50, 80))
					issue(cur_start + START_W'($urandom_range(0, 1)),
						DUR_W'($urandom_range(2000, 9000)));
				issue(cur_start + START_W'(10000), stream_dur());
			end else begin
				repeat ($urandom_range(5, 15)) begin
					case ($urandom_range(0, 3))
						0: begin
							if (cur_start != '0)
								issue(rand_start() % cur_start,
									DUR_W'({$urandom(), $urandom()}));
							else
								issue(cur_start, '0);
						end
						1: issue(cur_start, '0);
						2: issue(cur_start, DUR_W'(1));
						default: issue(cur_start + (rand_start() >> 24), stream_dur());
					endcase
				end
			end
		end

		// Top of the start range: no later start can exceed these.
		issue(START_MAX, '0);
		issue(START_MAX, DUR_MAX);
		issue(START_MAX, NEVER);
		issue(START_MAX - START_W'(1), DUR_W'(5));
		issue(START_MAX, '0);
		s_tvalid <= 1'b0;

		// Drain, then allow the pipeline latency for any stray transfer.
		while (results_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
